/* hdl/vertex_rotate_xyz_fixed_assert.svh */
// Assertion macros used by the vertex rotation top level.
`ifndef VERTEX_ROTATE_XYZ_FIXED_ASSERT_SVH
`define VERTEX_ROTATE_XYZ_FIXED_ASSERT_SVH

`ifndef SYNTHESIS

`define VRX_ASSERT(label, prop) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error("%m: assertion failed");

`define VRX_ASSERT_NR(label, prop) \
    label: assert property (@(posedge aclk) prop) \
        else $error("%m: assertion failed");

`else

`define VRX_ASSERT(label, prop)

`define VRX_ASSERT_NR(label, prop)

`endif

`endif

/* hdl/vrx_pkg.sv */
// Shared constants and types of the fixed-point XYZ vertex rotation block.
package vrx_pkg;

    localparam int REG_W       = 14;
    localparam int IN_W        = 24;
    localparam int OUT_W       = 26;
    localparam int TRIG_SCALE  = 4096;
    localparam int SCALE_SHIFT = $clog2(TRIG_SCALE);
    localparam int NUM_REGS    = 6;
    localparam int CFG_IDX_W   = 3;

    localparam int IN_TDATA_W  = ((3 * IN_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((3 * OUT_W + 7) / 8) * 8;

    localparam logic [CFG_IDX_W-1:0] REG_COS_X = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_SIN_X = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_COS_Y = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_SIN_Y = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] REG_COS_Z = CFG_IDX_W'(4);
    localparam logic [CFG_IDX_W-1:0] REG_SIN_Z = CFG_IDX_W'(5);

    typedef struct packed {
        logic prod_ld;
        logic sum_ld;
    } vrx_stage_ld_t;

endpackage

/* hdl/vertex_rotate_xyz_fixed.sv */
// Top level of the fixed-point XYZ Euler vertex rotation pipeline.
//
// Each transaction carries one signed vector that is rotated about X, then Y, then Z
// using six 14-bit fixed-point sine and cosine registers whose unit value is 4096.
// The pipeline takes one transaction per cycle; each transaction passes through one
// product stage and one sum stage for each of the three axes, in axis order.
// Each stage advances on its own when the stage after it has room, so a stalled
// output only blocks the input once every stage holds a vector. Results wider than
// 26 bits wrap. Write the registers only while no transaction is in flight.
module vertex_rotate_xyz_fixed (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // Fields from bit 0: in_x, in_y, in_z.
    input  logic [vrx_pkg::IN_TDATA_W-1:0]        s_tdata,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // Fields from bit 0: out_x, out_y, out_z, then zero padding.
    output logic [vrx_pkg::OUT_TDATA_W-1:0]       m_tdata,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [vrx_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [vrx_pkg::REG_W-1:0]             cfg_data
);
    import vrx_pkg::*;

    `include "vertex_rotate_xyz_fixed_assert.svh"

    localparam int NSTG = 6;
    localparam int W1 = IN_W + REG_W + 1 - SCALE_SHIFT;
    localparam int W2 = ((W1 > IN_W) ? W1 : IN_W) + REG_W + 1 - SCALE_SHIFT;
    localparam int W3 = ((W2 > W1) ? W2 : W1) + REG_W + 1 - SCALE_SHIFT;

    logic signed [REG_W-1:0] cos_x_reg, sin_x_reg, cos_y_reg, sin_y_reg;
    logic signed [REG_W-1:0] cos_z_reg, sin_z_reg;

    logic [NSTG-1:0] valid_reg;
    logic [NSTG:0]   load;

    logic signed [IN_W-1:0] in_x, in_y, in_z;
    logic signed [IN_W-1:0] x_s0_reg, x_s1_reg;
    logic signed [W1-1:0]   y1, z1, y1_s2_reg, y1_s3_reg;
    logic signed [W2-1:0]   z2, x2, z2_s4_reg, z2_s5_reg;
    logic signed [W3-1:0]   x3, y3;

    vrx_stage_ld_t ld_x, ld_y, ld_z;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cos_x_reg <= REG_W'(TRIG_SCALE);
            sin_x_reg <= '0;
            cos_y_reg <= REG_W'(TRIG_SCALE);
            sin_y_reg <= '0;
            cos_z_reg <= REG_W'(TRIG_SCALE);
            sin_z_reg <= '0;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_COS_X: cos_x_reg <= cfg_data;
                REG_SIN_X: sin_x_reg <= cfg_data;
                REG_COS_Y: cos_y_reg <= cfg_data;
                REG_SIN_Y: sin_y_reg <= cfg_data;
                REG_COS_Z: cos_z_reg <= cfg_data;
                REG_SIN_Z: sin_z_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // A stage loads when it is empty or its content moves on.
    always_comb begin
        load[NSTG] = m_tready;
        for (int k = NSTG - 1; k >= 0; k--) begin
            load[k] = !valid_reg[k] || load[k+1];
        end
    end

    assign s_tready = load[0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            if (load[0]) begin
                valid_reg[0] <= s_tvalid;
            end
            for (int k = 1; k < NSTG; k++) begin
                if (load[k]) begin
                    valid_reg[k] <= valid_reg[k-1];
                end
            end
        end
    end

    assign in_x = s_tdata[IN_W-1:0];
    assign in_y = s_tdata[2*IN_W-1:IN_W];
    assign in_z = s_tdata[3*IN_W-1:2*IN_W];

    assign ld_x = '{prod_ld: load[0], sum_ld: load[1]};
    assign ld_y = '{prod_ld: load[2], sum_ld: load[3]};
    assign ld_z = '{prod_ld: load[4], sum_ld: load[5]};

    always_ff @(posedge aclk) begin
        if (load[0]) x_s0_reg  <= in_x;
        if (load[1]) x_s1_reg  <= x_s0_reg;
        if (load[2]) y1_s2_reg <= y1;
        if (load[3]) y1_s3_reg <= y1_s2_reg;
        if (load[4]) z2_s4_reg <= z2;
        if (load[5]) z2_s5_reg <= z2_s4_reg;
    end

    vrx_rot_axis #(.WA(IN_W), .WB(IN_W)) u_rot_x (
        .aclk (aclk),
        .ld   (ld_x),
        .a    (in_y),
        .b    (in_z),
        .c    (cos_x_reg),
        .s    (sin_x_reg),
        .p    (y1),
        .q    (z1)
    );

    vrx_rot_axis #(.WA(W1), .WB(IN_W)) u_rot_y (
        .aclk (aclk),
        .ld   (ld_y),
        .a    (z1),
        .b    (x_s1_reg),
        .c    (cos_y_reg),
        .s    (sin_y_reg),
        .p    (z2),
        .q    (x2)
    );

    vrx_rot_axis #(.WA(W2), .WB(W1)) u_rot_z (
        .aclk (aclk),
        .ld   (ld_z),
        .a    (x2),
        .b    (y1_s3_reg),
        .c    (cos_z_reg),
        .s    (sin_z_reg),
        .p    (x3),
        .q    (y3)
    );

    assign m_tvalid = valid_reg[NSTG-1];
    assign m_tdata  = {{(OUT_TDATA_W - 3 * OUT_W){1'b0}},
                       z2_s5_reg[OUT_W-1:0], y3[OUT_W-1:0], x3[OUT_W-1:0]};

    `VRX_ASSERT(a_full_blocks_input, ((&valid_reg) && !m_tready) |-> !s_tready)
    `VRX_ASSERT(a_fill_count, (s_tvalid && s_tready && !(m_tvalid && m_tready))
        |=> ($countones(valid_reg) == $past($countones(valid_reg)) + 1))
    `VRX_ASSERT(a_drain_count, (m_tvalid && m_tready && !(s_tvalid && s_tready))
        |=> ($countones(valid_reg) + 1 == $past($countones(valid_reg))))
    `VRX_ASSERT_NR(a_reset_empty, !aresetn |=> !m_tvalid)

endmodule

/* hdl/vrx_rot_axis.sv */
// Two-stage planar rotation: registered products, then registered sums scaled toward zero.
module vrx_rot_axis #(
    parameter int WA = vrx_pkg::IN_W,
    parameter int WB = vrx_pkg::IN_W,
    localparam int WP = ((WA > WB) ? WA : WB) + vrx_pkg::REG_W,
    localparam int WS = WP + 1,
    localparam int WO = WS - vrx_pkg::SCALE_SHIFT
) (
    input  logic                           aclk,
    input  vrx_pkg::vrx_stage_ld_t         ld,
    input  logic signed [WA-1:0]           a,
    input  logic signed [WB-1:0]           b,
    input  logic signed [vrx_pkg::REG_W-1:0] c,
    input  logic signed [vrx_pkg::REG_W-1:0] s,
    output logic signed [WO-1:0]           p,
    output logic signed [WO-1:0]           q
);
    import vrx_pkg::*;

    logic signed [WP-1:0] ac_reg, bs_reg, as_reg, bc_reg;
    logic signed [WP-1:0] ac_next, bs_next, as_next, bc_next;
    logic signed [WS-1:0] diff_sum, plus_sum;
    logic signed [WO-1:0] p_reg, q_reg, p_next, q_next;

    // Division by the trig scale, truncating toward zero.
    function automatic logic signed [WO-1:0] scale_down(input logic signed [WS-1:0] v);
        logic signed [WS-1:0] adj;
        adj = v + $signed({{(WS - SCALE_SHIFT){1'b0}}, {SCALE_SHIFT{v[WS-1]}}});
        return adj[WS-1:SCALE_SHIFT];
    endfunction

    always_comb begin
        ac_next  = a * c;
        bs_next  = b * s;
        as_next  = a * s;
        bc_next  = b * c;
        diff_sum = WS'(ac_reg) - WS'(bs_reg);
        plus_sum = WS'(as_reg) + WS'(bc_reg);
        p_next   = scale_down(diff_sum);
        q_next   = scale_down(plus_sum);
    end

    always_ff @(posedge aclk) begin
        if (ld.prod_ld) begin
            ac_reg <= ac_next;
            bs_reg <= bs_next;
            as_reg <= as_next;
            bc_reg <= bc_next;
        end
        if (ld.sum_ld) begin
            p_reg <= p_next;
            q_reg <= q_next;
        end
    end

    assign p = p_reg;
    assign q = q_reg;

endmodule
